// ----- rtl/core/max_sum_square_window_assert.svh -----
// ----------------------------------------------------------------------------
// max_sum_square_window_assert.svh
// Assertion macros used by the max_sum_square_window top level.
// The macros expect clk and an active-low rst_n in the scope of use.
// ----------------------------------------------------------------------------
`ifndef MAX_SUM_SQUARE_WINDOW_ASSERT_SVH
`define MAX_SUM_SQUARE_WINDOW_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define MSSW_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mssw: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define MSSW_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mssw: next-cycle check failed");

`endif

// ----- rtl/core/mssw_pkg.sv -----
// ----------------------------------------------------------------------------
// mssw_pkg
// Shared constants, item and result types of the maximum-sum window block.
// ----------------------------------------------------------------------------
package mssw_pkg;

  // Matrix geometry.
  localparam int MAX_SIDE   = 64;
  localparam int SIDE_W     = $clog2(MAX_SIDE);
  localparam int END_W      = SIDE_W + 1;
  localparam int SMEM_DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int ADDR_W     = 2 * SIDE_W;

  // Field and datapath widths.
  localparam int SAMPLE_W = 16;
  localparam int POS_W    = 7;
  localparam int SUM_W    = 28;
  localparam int COL_W    = SAMPLE_W + SIDE_W;
  localparam int WIN_W    = SAMPLE_W + 2 * SIDE_W;

  // Most negative window sum, the cleared value of the best sum.
  localparam logic signed [WIN_W-1:0] WIN_MIN = {1'b1, {(WIN_W-1){1'b0}}};

  // Configuration registers.
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_MATRIX_SIZE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 1'd1;
  localparam logic [CFG_W-1:0] MATRIX_SIZE_RST = 7'd64;
  localparam logic [CFG_W-1:0] WINDOW_SIZE_RST = 7'd1;

  // Queues.
  localparam int IQ_DEPTH = 4;
  localparam int IQ_PTR_W = $clog2(IQ_DEPTH);
  localparam int IQ_CNT_W = $clog2(IQ_DEPTH + 1);
  localparam int OQ_DEPTH = 8;
  localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

  // One classified sample, passed from the front to the back.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic [SIDE_W-1:0]          row;
    logic [SIDE_W-1:0]          col;
    logic [SIDE_W-1:0]          row_back;  // row leaving the column sum
    logic [SIDE_W-1:0]          col_back;  // column leaving the window sum
    logic                       start;     // first sample of a matrix
    logic                       last;      // last sample of a matrix
    logic                       sub_col;   // drop the old sample from the column
    logic                       sub_win;   // drop the old column from the window
    logic                       cand;      // a full window ends here
    logic                       fwd;       // window is one column wide
    logic                       kzero;     // empty window
  } item_t;

  // One result request.
  typedef struct packed {
    logic [POS_W-1:0]        end_row;
    logic [POS_W-1:0]        end_col;
    logic signed [SUM_W-1:0] best_sum;
    logic                    found;
  } result_t;

  // Occupancy seen by the top level.
  typedef struct packed {
    logic [OQ_CNT_W-1:0] oq_cnt;
    logic [1:0]          inflight;
  } back_stat_t;

endpackage

// ----- rtl/core/mssw_front.sv -----
// ----------------------------------------------------------------------------
// mssw_front
// Accepts samples, tracks the raster position and classifies each sample.
// ----------------------------------------------------------------------------
module mssw_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_push,
  input  logic signed [mssw_pkg::SAMPLE_W-1:0] in_sample_value,
  output logic                              in_full,
  input  logic                              cfg_we,
  input  logic [mssw_pkg::CFG_W-1:0]        matrix_size,
  input  logic [mssw_pkg::CFG_W-1:0]        window_size,
  input  logic                              iq_full,
  output logic                              iq_push,
  output mssw_pkg::item_t                   iq_item
);

  logic [mssw_pkg::SIDE_W-1:0] row_r;
  logic [mssw_pkg::SIDE_W-1:0] col_r;
  logic [mssw_pkg::END_W-1:0]  side;
  logic [mssw_pkg::SIDE_W-1:0] last_idx;
  int                          kk;
  int                          rr;
  int                          cc;
  int                          nn;

  // Effective matrix side: zero counts as one, large values saturate.
  always_comb begin
    if (matrix_size == '0) begin
      side = mssw_pkg::END_W'(1);
    end else if (32'(matrix_size) > mssw_pkg::MAX_SIDE) begin
      side = mssw_pkg::END_W'(mssw_pkg::MAX_SIDE);
    end else begin
      side = mssw_pkg::END_W'(matrix_size);
    end
  end

  assign last_idx = mssw_pkg::SIDE_W'(side - mssw_pkg::END_W'(1));

  assign in_full = iq_full;
  assign iq_push = in_push && !iq_full;

  // Raster position of the next sample; a configuration write restarts it.
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we) begin
      row_r <= '0;
      col_r <= '0;
    end else if (iq_push) begin
      if (col_r == last_idx) begin
        col_r <= '0;
        row_r <= (row_r == last_idx) ? '0 : row_r + 1'b1;
      end else begin
        col_r <= col_r + 1'b1;
      end
    end
  end

  assign kk = 32'(window_size);
  assign rr = 32'(row_r);
  assign cc = 32'(col_r);
  assign nn = 32'(side);

  // Classification of the sample at the current position.
  always_comb begin
    iq_item.sample   = in_sample_value;
    iq_item.row      = row_r;
    iq_item.col      = col_r;
    iq_item.row_back = mssw_pkg::SIDE_W'(rr - kk);
    iq_item.col_back = mssw_pkg::SIDE_W'(cc - kk);
    iq_item.start    = (row_r == '0) && (col_r == '0);
    iq_item.last     = (row_r == last_idx) && (col_r == last_idx);
    iq_item.sub_col  = (kk >= 1) && (rr >= kk);
    iq_item.sub_win  = (kk >= 1) && (cc >= kk);
    iq_item.cand     = (kk >= 1) && (kk <= nn) && (rr + 1 >= kk) && (cc + 1 >= kk);
    iq_item.fwd      = (kk == 1);
    iq_item.kzero    = (kk == 0);
  end

endmodule

// ----- rtl/core/mssw_iq.sv -----
// ----------------------------------------------------------------------------
// mssw_iq
// Short queue of classified samples between the front and the back.
// ----------------------------------------------------------------------------
module mssw_iq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  mssw_pkg::item_t push_item,
  input  logic            pop,
  output mssw_pkg::item_t head_item,
  output logic            empty,
  output logic            full
);

  mssw_pkg::item_t                 slot_r [mssw_pkg::IQ_DEPTH];
  logic [mssw_pkg::IQ_PTR_W-1:0]   wr_r;
  logic [mssw_pkg::IQ_PTR_W-1:0]   rd_r;
  logic [mssw_pkg::IQ_CNT_W-1:0]   cnt_r;
  logic                            do_push;
  logic                            do_pop;

  assign empty   = (cnt_r == '0);
  assign full    = (cnt_r == mssw_pkg::IQ_CNT_W'(mssw_pkg::IQ_DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  assign head_item = slot_r[rd_r];

  // Storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_r] <= push_item;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wr_r <= (wr_r == mssw_pkg::IQ_PTR_W'(mssw_pkg::IQ_DEPTH - 1)) ? '0 : wr_r + 1'b1;
      end
      if (do_pop) begin
        rd_r <= (rd_r == mssw_pkg::IQ_PTR_W'(mssw_pkg::IQ_DEPTH - 1)) ? '0 : rd_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/core/mssw_back.sv -----
// ----------------------------------------------------------------------------
// mssw_back
// Sum pipeline: sample store, column sums, window sum, best tracking and the
// result queue.
// ----------------------------------------------------------------------------
module mssw_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 iq_empty,
  input  mssw_pkg::item_t      iq_item,
  output logic                 iq_pop,
  input  logic                 out_pop,
  output logic                 out_empty,
  output mssw_pkg::result_t    out_result,
  output mssw_pkg::back_stat_t stat
);

  // Memories.
  logic signed [mssw_pkg::SAMPLE_W-1:0] smem   [mssw_pkg::SMEM_DEPTH];
  logic signed [mssw_pkg::COL_W-1:0]    cmem_a [mssw_pkg::MAX_SIDE];
  logic signed [mssw_pkg::COL_W-1:0]    cmem_b [mssw_pkg::MAX_SIDE];
  logic signed [mssw_pkg::SAMPLE_W-1:0] old_sample_r;
  logic signed [mssw_pkg::COL_W-1:0]    col_here_r;
  logic signed [mssw_pkg::COL_W-1:0]    col_back_r;

  // Stage two: column update.
  logic                                 s2_vld_r;
  mssw_pkg::item_t                      s2_item_r;
  logic [mssw_pkg::MAX_SIDE-1:0]        col_vld_r;
  logic [mssw_pkg::MAX_SIDE-1:0]        col_vld_nxt;
  logic signed [mssw_pkg::COL_W-1:0]    col_prev;
  logic signed [mssw_pkg::COL_W-1:0]    s_ext;
  logic signed [mssw_pkg::COL_W-1:0]    o_ext;
  logic signed [mssw_pkg::COL_W-1:0]    col_new;

  // Stage three: window update.
  logic                                 s3_vld_r;
  mssw_pkg::item_t                      s3_item_r;
  logic signed [mssw_pkg::COL_W-1:0]    s3_col_r;
  logic signed [mssw_pkg::COL_W-1:0]    s3_back_r;
  logic signed [mssw_pkg::COL_W-1:0]    last_col_r;
  logic signed [mssw_pkg::COL_W-1:0]    col_sub;
  logic signed [mssw_pkg::WIN_W-1:0]    win_r;
  logic signed [mssw_pkg::WIN_W-1:0]    win_base;
  logic signed [mssw_pkg::WIN_W-1:0]    win_nxt;

  // Stage four: best window.
  logic                                 s4_vld_r;
  mssw_pkg::item_t                      s4_item_r;
  logic signed [mssw_pkg::WIN_W-1:0]    s4_win_r;
  logic signed [mssw_pkg::WIN_W-1:0]    best_r;
  logic signed [mssw_pkg::WIN_W-1:0]    best_eff;
  logic signed [mssw_pkg::WIN_W-1:0]    best_nxt;
  logic [mssw_pkg::END_W-1:0]           brow_r;
  logic [mssw_pkg::END_W-1:0]           bcol_r;
  logic [mssw_pkg::END_W-1:0]           brow_nxt;
  logic [mssw_pkg::END_W-1:0]           bcol_nxt;
  logic                                 any_r;
  logic                                 any_eff;
  logic                                 any_nxt;
  logic                                 take;
  mssw_pkg::result_t                    res;

  // Result queue.
  mssw_pkg::result_t                    oq_mem [mssw_pkg::OQ_DEPTH];
  logic [mssw_pkg::OQ_PTR_W-1:0]        oq_wr_r;
  logic [mssw_pkg::OQ_PTR_W-1:0]        oq_rd_r;
  logic [mssw_pkg::OQ_CNT_W-1:0]        oq_cnt_r;
  logic                                 oq_push;
  logic                                 oq_pop;
  logic [1:0]                           inflight;

  // Issue only when the result queue can hold every item in flight.
  assign inflight = 2'(s2_vld_r) + 2'(s3_vld_r) + 2'(s4_vld_r);
  assign iq_pop   = !iq_empty && ((32'(oq_cnt_r) + 32'(inflight)) < mssw_pkg::OQ_DEPTH);

  // Sample store: write the new sample, read the one leaving the column.
  always_ff @(posedge clk) begin
    if (iq_pop) begin
      smem[{iq_item.row, iq_item.col}] <= iq_item.sample;
    end
    old_sample_r <= smem[{iq_item.row_back, iq_item.col}];
  end

  // Column sums, kept twice so that two columns can be read per cycle.
  always_ff @(posedge clk) begin
    if (s2_vld_r) begin
      cmem_a[s2_item_r.col] <= col_new;
      cmem_b[s2_item_r.col] <= col_new;
    end
    col_here_r <= cmem_a[iq_item.col];
    col_back_r <= cmem_b[iq_item.col_back];
  end

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= iq_pop;
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r;
    end
  end

  // Stage payloads.
  always_ff @(posedge clk) begin
    s2_item_r <= iq_item;
    s3_item_r <= s2_item_r;
    s3_col_r  <= col_new;
    s3_back_r <= col_back_r;
    s4_item_r <= s3_item_r;
    s4_win_r  <= win_nxt;
  end

  // New column sum; a column not yet written in this matrix reads as zero.
  always_comb begin
    col_prev = (s2_item_r.start || !col_vld_r[s2_item_r.col]) ? '0 : col_here_r;
    s_ext    = mssw_pkg::COL_W'(s2_item_r.sample);
    o_ext    = s2_item_r.sub_col ? mssw_pkg::COL_W'(old_sample_r) : '0;
    col_new  = col_prev + s_ext - o_ext;
    col_vld_nxt = s2_item_r.start ? '0 : col_vld_r;
    col_vld_nxt[s2_item_r.col] = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_vld_r <= '0;
    end else if (s2_vld_r) begin
      col_vld_r <= col_vld_nxt;
    end
  end

  // Sliding window sum; a one-column window takes the previous column directly.
  always_comb begin
    if (!s3_item_r.sub_win) begin
      col_sub = '0;
    end else if (s3_item_r.fwd) begin
      col_sub = last_col_r;
    end else begin
      col_sub = s3_back_r;
    end
    win_base = (s3_item_r.col == '0) ? '0 : win_r;
    win_nxt  = win_base + mssw_pkg::WIN_W'(s3_col_r) - mssw_pkg::WIN_W'(col_sub);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (s3_vld_r) begin
      win_r <= win_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_vld_r) begin
      last_col_r <= s3_col_r;
    end
  end

  // Best window so far; ties keep the earlier window.
  always_comb begin
    any_eff  = s4_item_r.start ? 1'b0 : any_r;
    best_eff = s4_item_r.start ? mssw_pkg::WIN_MIN : best_r;
    take     = s4_item_r.cand && (!any_eff || (s4_win_r > best_eff));
    any_nxt  = any_eff || s4_item_r.cand;
    if (take) begin
      best_nxt = s4_win_r;
      brow_nxt = mssw_pkg::END_W'(s4_item_r.row) + mssw_pkg::END_W'(1);
      bcol_nxt = mssw_pkg::END_W'(s4_item_r.col) + mssw_pkg::END_W'(1);
    end else begin
      best_nxt = best_eff;
      brow_nxt = s4_item_r.start ? '0 : brow_r;
      bcol_nxt = s4_item_r.start ? '0 : bcol_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      any_r  <= 1'b0;
      best_r <= mssw_pkg::WIN_MIN;
      brow_r <= '0;
      bcol_r <= '0;
    end else if (s4_vld_r) begin
      any_r  <= any_nxt;
      best_r <= best_nxt;
      brow_r <= brow_nxt;
      bcol_r <= bcol_nxt;
    end
  end

  // Result request for the last sample of a matrix.
  always_comb begin
    res = '0;
    if (s4_item_r.kzero) begin
      res.found = 1'b1;
    end else if (any_nxt) begin
      res.end_row  = mssw_pkg::POS_W'(brow_nxt);
      res.end_col  = mssw_pkg::POS_W'(bcol_nxt);
      res.best_sum = mssw_pkg::SUM_W'(best_nxt);
      res.found    = 1'b1;
    end
  end

  assign oq_push    = s4_vld_r && s4_item_r.last;
  assign out_empty  = (oq_cnt_r == '0);
  assign oq_pop     = out_pop && !out_empty;
  assign out_result = oq_mem[oq_rd_r];

  always_ff @(posedge clk) begin
    if (oq_push) begin
      oq_mem[oq_wr_r] <= res;
    end
  end

  // Result queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wr_r  <= '0;
      oq_rd_r  <= '0;
      oq_cnt_r <= '0;
    end else begin
      if (oq_push) begin
        oq_wr_r <= (oq_wr_r == mssw_pkg::OQ_PTR_W'(mssw_pkg::OQ_DEPTH - 1)) ?
                   '0 : oq_wr_r + 1'b1;
      end
      if (oq_pop) begin
        oq_rd_r <= (oq_rd_r == mssw_pkg::OQ_PTR_W'(mssw_pkg::OQ_DEPTH - 1)) ?
                   '0 : oq_rd_r + 1'b1;
      end
      if (oq_push && !oq_pop) begin
        oq_cnt_r <= oq_cnt_r + 1'b1;
      end else if (oq_pop && !oq_push) begin
        oq_cnt_r <= oq_cnt_r - 1'b1;
      end
    end
  end

  assign stat.oq_cnt   = oq_cnt_r;
  assign stat.inflight = inflight;

endmodule

// ----- rtl/core/max_sum_square_window.sv -----
// ----------------------------------------------------------------------------
// max_sum_square_window
// Finds the k-by-k window of greatest sum in a streamed square matrix.
// ----------------------------------------------------------------------------
// Usage:
// Samples arrive in raster order on the in_ queue port (push/full), one per
// cycle while full is low. After the last sample of an n-by-n matrix one result
// request appears on the out_ queue port (empty/pop): the exclusive end row
// and column of the best window, its sum and a found flag.
// Throughput is one sample per cycle while issue is not stalled, set by the
// single write port of the sample store and the read-modify-write of one
// column sum per cycle. The result of the last sample passes the input queue,
// the stage two to four registers and the result queue before empty goes low.
// The cfg_ port writes matrix_size (index 0) or window_size (index 1);
// cfg_ready is always high. A write restarts the raster position.
// Reset restores the register defaults and empties both queues; there is no
// clearing pass, so samples are taken right after reset.
// When the receiver does not pop, up to eight results wait. The sum pipeline
// stops issuing once waiting results and samples in flight reach eight, and
// full rises once the input queue fills.
// ----------------------------------------------------------------------------
module max_sum_square_window (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_push,
  output logic                                  in_full,
  input  logic signed [mssw_pkg::SAMPLE_W-1:0]  in_sample_value,
  output logic                                  out_empty,
  input  logic                                  out_pop,
  output logic [mssw_pkg::POS_W-1:0]            out_end_row,
  output logic [mssw_pkg::POS_W-1:0]            out_end_col,
  output logic signed [mssw_pkg::SUM_W-1:0]     out_best_sum,
  output logic                                  out_found,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [mssw_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [mssw_pkg::CFG_W-1:0]            cfg_data
);

  logic [mssw_pkg::CFG_W-1:0] matrix_size_r;
  logic [mssw_pkg::CFG_W-1:0] window_size_r;
  logic                       cfg_we;
  logic                       iq_push;
  logic                       iq_pop;
  logic                       iq_empty;
  logic                       iq_full;
  mssw_pkg::item_t            front_item;
  mssw_pkg::item_t            head_item;
  mssw_pkg::result_t          result;
  mssw_pkg::back_stat_t       back_stat;
  int                         credit_used;

  // Configuration registers.
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      matrix_size_r <= mssw_pkg::MATRIX_SIZE_RST;
      window_size_r <= mssw_pkg::WINDOW_SIZE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        mssw_pkg::REG_MATRIX_SIZE: matrix_size_r <= cfg_data;
        mssw_pkg::REG_WINDOW_SIZE: window_size_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Front: position tracking and classification.
  mssw_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_sample_value (in_sample_value),
    .in_full         (in_full),
    .cfg_we          (cfg_we),
    .matrix_size     (matrix_size_r),
    .window_size     (window_size_r),
    .iq_full         (iq_full),
    .iq_push         (iq_push),
    .iq_item         (front_item)
  );

  // Queue between front and back.
  mssw_iq u_iq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (iq_push),
    .push_item (front_item),
    .pop       (iq_pop),
    .head_item (head_item),
    .empty     (iq_empty),
    .full      (iq_full)
  );

  // Back: sums, best tracking and result queue.
  mssw_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .iq_empty   (iq_empty),
    .iq_item    (head_item),
    .iq_pop     (iq_pop),
    .out_pop    (out_pop),
    .out_empty  (out_empty),
    .out_result (result),
    .stat       (back_stat)
  );

  assign out_end_row  = result.end_row;
  assign out_end_col  = result.end_col;
  assign out_best_sum = result.best_sum;
  assign out_found    = result.found;

  // Checks on the credit scheme and the front-to-back queue.
  `include "max_sum_square_window_assert.svh"

  assign credit_used = 32'(back_stat.oq_cnt) + 32'(back_stat.inflight);

  `MSSW_ASSERT_IMP(a_credit_bound, 1'b1, credit_used <= mssw_pkg::OQ_DEPTH)
  `MSSW_ASSERT_IMP(a_issue_has_item, iq_pop, !iq_empty)
  `MSSW_ASSERT_NXT(a_accept_queued, in_push && !in_full, !iq_empty)

endmodule

// ----- tb/max_sum_square_window_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_sum_square_window_test
// Streams square matrices into the maximum-sum window block and checks every
// result against a cycle-free model of the running column and window sums.
// Covers register corner values, aborted matrices, ties, output back-pressure
// and a partial matrix at the largest side. Both queue sides idle at random
// in several phases.
// ----------------------------------------------------------------------------

// Tracks the block's registers and sums, and holds the results still owed.
class best_window_board;
  logic [mssw_pkg::CFG_W-1:0]            side_reg;
  logic [mssw_pkg::CFG_W-1:0]            win_reg;
  logic signed [mssw_pkg::SAMPLE_W-1:0]  grid [mssw_pkg::MAX_SIDE][mssw_pkg::MAX_SIDE];
  longint                                col_sum [mssw_pkg::MAX_SIDE];
  longint                                run_sum;
  longint                                best_val;
  int                                    best_r;
  int                                    best_c;
  int                                    row_pos;
  int                                    col_pos;
  bit                                    have_best;
  mssw_pkg::result_t                     pending_answers [$];
  int unsigned                           errors;

  function new();
    side_reg = mssw_pkg::MATRIX_SIZE_RST;
    win_reg  = mssw_pkg::WINDOW_SIZE_RST;
    foreach (grid[r, c]) grid[r][c] = '0;
    restart();
    row_pos = 0;
    col_pos = 0;
    errors  = 0;
  endfunction

  // Clears the per-matrix sums and the best window found so far.
  function void restart();
    foreach (col_sum[i]) col_sum[i] = 0;
    run_sum   = 0;
    best_val  = -134217728;  // most negative 28-bit sum
    best_r    = 0;
    best_c    = 0;
    have_best = 1'b0;
  endfunction

  // Any register write also drops a matrix in progress.
  function void write_reg(logic [mssw_pkg::CFG_IDX_W-1:0] idx,
                          logic [mssw_pkg::CFG_W-1:0] val);
    if (idx == mssw_pkg::REG_MATRIX_SIZE) side_reg = val;
    else if (idx == mssw_pkg::REG_WINDOW_SIZE) win_reg = val;
    row_pos = 0;
    col_pos = 0;
  endfunction

  function int unsigned pending_count();
    return pending_answers.size();
  endfunction

  // Folds one accepted sample into the sums; queues the answer at matrix end.
  function void take_sample(logic signed [mssw_pkg::SAMPLE_W-1:0] s);
    int                n;
    int                k;
    int                r;
    int                c;
    mssw_pkg::result_t ans;
    n = (side_reg == 0) ? 1 : ((side_reg > mssw_pkg::MAX_SIDE) ? mssw_pkg::MAX_SIDE
                                                               : int'(side_reg));
    k = int'(win_reg);
    r = (row_pos >= n) ? n - 1 : row_pos;
    c = (col_pos >= n) ? n - 1 : col_pos;
    if (r == 0 && c == 0) restart();

    // Column sum over the last k rows, then window sum over the last k columns.
    grid[r][c] = s;
    col_sum[c] += s;
    if (k >= 1 && r >= k) col_sum[c] -= grid[r - k][c];
    if (c == 0) run_sum = 0;
    run_sum += col_sum[c];
    if (k >= 1 && c >= k) run_sum -= col_sum[c - k];

    // A full window ends here; a tie keeps the earlier window.
    if (k >= 1 && k <= n && r + 1 >= k && c + 1 >= k) begin
      if (!have_best || run_sum > best_val) begin
        best_val = run_sum;
        best_r   = r + 1;
        best_c   = c + 1;
      end
      have_best = 1'b1;
    end

    if (r == n - 1 && c == n - 1) begin
      row_pos = 0;
      col_pos = 0;
      ans = '0;
      if (k == 0) begin
        ans.found = 1'b1;
      end else if (have_best) begin
        ans.end_row  = best_r[mssw_pkg::POS_W-1:0];
        ans.end_col  = best_c[mssw_pkg::POS_W-1:0];
        ans.best_sum = best_val[mssw_pkg::SUM_W-1:0];
        ans.found    = 1'b1;
      end
      pending_answers.push_back(ans);
      return;
    end

    c++;
    if (c == n) begin
      c = 0;
      r++;
    end
    row_pos = r;
    col_pos = c;
  endfunction

  function void compare(string field, longint want, longint got);
    if (want != got) begin
      errors++;
      $display("%0t: %s expected %0d, actual %0d", $time, field, want, got);
    end
  endfunction

  // Checks one popped result against the oldest answer owed.
  function void check_answer(logic [mssw_pkg::POS_W-1:0] row,
                             logic [mssw_pkg::POS_W-1:0] col,
                             logic signed [mssw_pkg::SUM_W-1:0] sum,
                             logic found);
    mssw_pkg::result_t want;
    if (pending_answers.size() == 0) begin
      errors++;
      $display("%0t: unexpected result, expected none, actual %0d %0d %0d %0d",
               $time, row, col, sum, found);
      return;
    end
    want = pending_answers.pop_front();
    compare("end_row", longint'(want.end_row), longint'(row));
    compare("end_col", longint'(want.end_col), longint'(col));
    compare("best_sum", longint'(want.best_sum), longint'(sum));
    compare("found", longint'(want.found), longint'(found));
  endfunction
endclass

module max_sum_square_window_test;

  localparam int          RESET_CYCLES  = 12;
  localparam int          SETTLE_CYCLES = 20;
  localparam int          HOLD_CYCLES   = 300;
  localparam int          RANDOM_ITEMS  = 1250;
  localparam int unsigned CYCLE_LIMIT   = 400000;

  localparam logic signed [mssw_pkg::SAMPLE_W-1:0] CORNER_SET [9] = '{
    16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF,
    16'sh7FFF, 16'sh0001, 16'shFFFF, 16'sh0000
  };

  typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_t;
  typedef enum {FILL_FULL, FILL_NARROW, FILL_FLAT, FILL_RAILS} fill_t;

  logic                                 clk;
  logic                                 rst_n           = 1'b0;
  logic                                 in_push         = 1'b0;
  logic                                 in_full;
  logic signed [mssw_pkg::SAMPLE_W-1:0] in_sample_value = '0;
  logic                                 out_empty;
  logic                                 out_pop         = 1'b0;
  logic [mssw_pkg::POS_W-1:0]           out_end_row;
  logic [mssw_pkg::POS_W-1:0]           out_end_col;
  logic signed [mssw_pkg::SUM_W-1:0]    out_best_sum;
  logic                                 out_found;
  logic                                 cfg_valid       = 1'b0;
  logic                                 cfg_ready;
  logic [mssw_pkg::CFG_IDX_W-1:0]       cfg_index       = mssw_pkg::REG_MATRIX_SIZE;
  logic [mssw_pkg::CFG_W-1:0]           cfg_data        = '0;

  int unsigned      send_idle_pct = 0;
  int unsigned      stall_pct     = 0;
  logic             recv_hold     = 1'b0;
  event             hold_off_ev;
  best_window_board board;

  max_sum_square_window u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_sample_value (in_sample_value),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_end_row     (out_end_row),
    .out_end_col     (out_end_col),
    .out_best_sum    (out_best_sum),
    .out_found       (out_found),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watch every handshake on the clock edge and feed the board in order.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) board.write_reg(cfg_index, cfg_data);
      if (in_push && !in_full) board.take_sample(in_sample_value);
      if (out_pop && !out_empty)
        board.check_answer(out_end_row, out_end_col, out_best_sum, out_found);
    end
  end

  // Result side: random stalls, or a long hold-off when one is requested.
  always @(posedge clk) begin
    if (recv_hold) out_pop <= 1'b0;
    else out_pop <= ($urandom_range(99) >= stall_pct);
  end

  initial forever begin
    @(hold_off_ev);
    recv_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    recv_hold <= 1'b0;
  end

  // Give up on a hung block.
  initial begin
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic set_idling(idle_t mode);
    case (mode)
      IDLE_NONE: begin
        send_idle_pct = 0;
        stall_pct <= 0;
      end
      IDLE_SEND: begin
        send_idle_pct = 74;
        stall_pct <= 0;
      end
      IDLE_RECV: begin
        send_idle_pct = 0;
        stall_pct <= 74;
      end
      default: begin
        send_idle_pct = 7;
        stall_pct <= 7;
      end
    endcase
  endtask

  // Leaves valid high so that a second write can follow at once.
  task automatic write_reg(logic [mssw_pkg::CFG_IDX_W-1:0] idx, int val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[mssw_pkg::CFG_W-1:0];
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Writes both registers in a random order.
  task automatic configure(int side, int win);
    if ($urandom_range(1)) begin
      write_reg(mssw_pkg::REG_MATRIX_SIZE, side);
      write_reg(mssw_pkg::REG_WINDOW_SIZE, win);
    end else begin
      write_reg(mssw_pkg::REG_WINDOW_SIZE, win);
      write_reg(mssw_pkg::REG_MATRIX_SIZE, side);
    end
    cfg_valid <= 1'b0;
  endtask

  // Offers one sample after a random idle stretch and holds it until taken.
  task automatic send_sample(logic signed [mssw_pkg::SAMPLE_W-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_push         <= 1'b0;
      in_sample_value <= mssw_pkg::SAMPLE_W'($urandom);
      @(posedge clk);
    end
    in_push         <= 1'b1;
    in_sample_value <= value;
    do @(posedge clk); while (in_full);
  endtask

  function automatic logic signed [mssw_pkg::SAMPLE_W-1:0] pick_sample(
      fill_t fill, logic signed [mssw_pkg::SAMPLE_W-1:0] flat);
    case (fill)
      FILL_FULL:   return mssw_pkg::SAMPLE_W'($urandom);
      FILL_NARROW: return mssw_pkg::SAMPLE_W'(int'($urandom_range(4)) - 2);
      FILL_FLAT:   return flat;
      default:     return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
    endcase
  endfunction

  task automatic send_samples(int count, fill_t fill);
    logic signed [mssw_pkg::SAMPLE_W-1:0] flat;
    flat = mssw_pkg::SAMPLE_W'($urandom);
    repeat (count) send_sample(pick_sample(fill, flat));
  endtask

  // Stop sending and wait until every owed result has been popped.
  task automatic wait_answers();
    in_push <= 1'b0;
    @(posedge clk);
    while (board.pending_count() != 0) @(posedge clk);
  endtask

  // Also let a partial matrix clear the pipeline before the next write.
  task automatic settle();
    wait_answers();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int random_items;
    int phase;
    int roll;
    int side_val;
    int win_val;
    int side_eff;
    int count;

    board = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: register corners, empty window, oversize window, abort, ties.
    set_idling(IDLE_NONE);
    configure(0, 1);
    send_sample(16'sh7FFF);
    settle();
    configure(0, 0);
    send_sample(16'sh8000);
    settle();
    configure(2, 127);
    send_samples(4, FILL_FULL);
    settle();
    configure(2, 1);
    send_samples(2, FILL_FULL);
    settle();
    configure(2, 1);
    send_samples(4, FILL_RAILS);
    settle();
    configure(3, 2);
    foreach (CORNER_SET[i]) send_sample(CORNER_SET[i]);
    settle();

    // Back-pressure: one result per sample while the receiver holds off.
    configure(1, 1);
    -> hold_off_ev;
    send_samples(48, FILL_FULL);
    settle();

    // Random phases, each with its own sizes and idling pattern.
    random_items = 0;
    phase = 0;
    while (random_items < RANDOM_ITEMS) begin
      set_idling(idle_t'(phase % 4));
      roll = $urandom_range(99);
      if (roll < 6) side_val = 0;
      else if (roll < 16) side_val = $urandom_range(12, 9);
      else side_val = $urandom_range(8, 1);
      side_eff = (side_val == 0) ? 1 : side_val;
      roll = $urandom_range(99);
      if (roll < 8) win_val = 0;
      else if (roll < 18) win_val = $urandom_range(127, side_eff + 1);
      else win_val = $urandom_range(side_eff, 1);
      configure(side_val, win_val);

      repeat ($urandom_range(6, 1)) begin
        send_samples(side_eff * side_eff, fill_t'($urandom_range(3)));
        random_items += side_eff * side_eff;
        if ($urandom_range(7) == 0) wait_answers();
      end

      // Sometimes leave a matrix unfinished; the next write drops it.
      if (side_eff > 1 && $urandom_range(3) == 0) begin
        count = $urandom_range(side_eff * side_eff - 1, 1);
        send_samples(count, fill_t'($urandom_range(3)));
        random_items += count;
      end
      settle();
      phase++;
    end

    // Oversize register value: a few rows of a full-width matrix, left unfinished.
    set_idling(IDLE_NONE);
    configure(127, 2);
    send_samples(2 * mssw_pkg::MAX_SIDE + 3, FILL_FULL);
    settle();

    if (board.errors == 0 && board.pending_count() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/mssw_pkg.sv
rtl/core/mssw_front.sv
rtl/core/mssw_iq.sv
rtl/core/mssw_back.sv
rtl/core/max_sum_square_window.sv
tb/max_sum_square_window_test.sv
